[src/nsi_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and state encoding for the NAL seek indexer.
package nsi_pkg;

	localparam int MAX_SEEK_POINTS = 1024;
	localparam int IDX_W = $clog2(MAX_SEEK_POINTS);
	localparam int CNT_W = IDX_W + 1;
	localparam int SEEK_W = 24 + 32;

	localparam logic [4:0] NAL_TYPE_SLICE = 5'd1;
	localparam logic [4:0] NAL_TYPE_IDR = 5'd5;
	localparam logic [4:0] NAL_TYPE_SPS = 5'd7;
	localparam logic [4:0] NAL_TYPE_PPS = 5'd8;
	localparam logic [4:0] NAL_TYPE_SPS_EXT = 5'd13;
	localparam logic [4:0] NAL_TYPE_SUBSET_SPS = 5'd15;
	localparam logic [4:0] NAL_TYPE_AUX_SLICE = 5'd19;
	localparam logic [4:0] NAL_TYPE_SLICE_EXT = 5'd20;
	localparam int FIRST_SLICE_BIT = 7;
	localparam logic [23:0] PICTURE_MAX = 24'hFFFFFF;

	localparam logic KIND_NAL = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic        kind;
		logic [7:0]  nal_header;
		logic [7:0]  payload_byte;
		logic        payload_present;
		logic [31:0] nal_offset;
		logic [23:0] target_frame;
		logic [23:0] current_position;
	} req_item_t;

	typedef struct packed {
		logic        counted_picture;
		logic        seek_point_added;
		logic        parameter_set;
		logic [31:0] unit_start;
		logic [23:0] picture_total;
		logic        mvc_present;
		logic [23:0] seek_frame;
		logic [31:0] seek_offset;
		logic        must_restart;
	} rsp_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NAL,
		ST_SEARCH,
		ST_ANSWER
	} state_t;

endpackage

[src/nsi_req_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel that carries one input item.
interface nsi_req_if;
	logic               valid;
	logic               ready;
	nsi_pkg::req_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[src/nsi_rsp_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel that carries one result item.
interface nsi_rsp_if;
	logic               valid;
	logic               ready;
	nsi_pkg::rsp_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[src/nsi_ram.sv]
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
module nsi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/nal_seek_index_core.sv]
`timescale 1ns / 1ps
// Top level of the NAL seek indexer: stream tracking, seek table and binary search.
// A NAL item passes through the NAL state to its result; a query runs a binary search of at
// most CNT_W steps and then answers; both results wait until the output register is free.
// Each search step waits on the registered read of the seek table memory.
// Reset clears all tracking state and the point count; table contents are never cleared.
module nal_seek_index_core (
	input  logic              clk,
	input  logic              arst_n,
	nsi_req_if.sink           req,
	nsi_rsp_if.source         rsp,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata
);
	nsi_pkg::state_t state_q, state_d;
	nsi_pkg::req_item_t item_q;
	nsi_pkg::rsp_item_t rsp_data_q, nal_rsp, query_rsp;
	logic rsp_valid_q;

	logic [31:0] stream_start_q, unit_start_q;
	logic sps_q, pps_q, after_q, mvc_q;
	logic [23:0] pic_count_q;
	logic [nsi_pkg::CNT_W-1:0] seek_count_q;

	logic [nsi_pkg::CNT_W-1:0] lo_q, hi_q, lo_n, hi_n;
	logic [nsi_pkg::IDX_W-1:0] mid_q, mid_n, mid0;
	logic [nsi_pkg::CNT_W:0] mid_sum;
	logic found_q;
	logic [23:0] best_frame_q;
	logic [31:0] best_off_q;
	logic search_le, search_more;

	logic take, out_free, commit_nal, answer;
	logic [nsi_pkg::IDX_W-1:0] ram_raddr;
	logic [nsi_pkg::SEEK_W-1:0] ram_rdata;
	logic [23:0] rd_frame;
	logic [31:0] rd_off;

	logic [4:0] nal_type;
	logic is_slice, is_pic, add_point;
	logic [31:0] us_n;
	logic after_n;
	logic [23:0] ans_frame;
	logic [31:0] sp_off;

	assign take = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign mid0 = seek_count_q[nsi_pkg::CNT_W-1:1];
	assign rd_frame = ram_rdata[nsi_pkg::SEEK_W-1:32];
	assign rd_off = ram_rdata[31:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nsi_pkg::ST_IDLE: begin
				if (take) begin
					if (req.data.kind == nsi_pkg::KIND_NAL) begin
						state_d = nsi_pkg::ST_NAL;
					end else if (seek_count_q == '0) begin
						state_d = nsi_pkg::ST_ANSWER;
					end else begin
						state_d = nsi_pkg::ST_SEARCH;
					end
				end
			end
			nsi_pkg::ST_NAL: begin
				if (out_free) begin
					state_d = nsi_pkg::ST_IDLE;
				end
			end
			nsi_pkg::ST_SEARCH: begin
				if (!search_more) begin
					state_d = nsi_pkg::ST_ANSWER;
				end
			end
			nsi_pkg::ST_ANSWER: begin
				if (out_free) begin
					state_d = nsi_pkg::ST_IDLE;
				end
			end
			default: state_d = nsi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == nsi_pkg::ST_IDLE);
		commit_nal = (state_q == nsi_pkg::ST_NAL) && out_free;
		answer = (state_q == nsi_pkg::ST_ANSWER) && out_free;
		ram_raddr = (state_q == nsi_pkg::ST_IDLE) ? mid0 : mid_n;
	end

	always_comb begin
		search_le = (rd_frame <= item_q.target_frame);
		lo_n = search_le ? (nsi_pkg::CNT_W'(mid_q) + 1'b1) : lo_q;
		hi_n = search_le ? hi_q : nsi_pkg::CNT_W'(mid_q);
		search_more = (lo_n < hi_n);
		mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
		mid_n = mid_sum[nsi_pkg::IDX_W:1];
	end

	always_comb begin
		nal_type = item_q.nal_header[4:0];
		is_slice = (nal_type >= nsi_pkg::NAL_TYPE_SLICE && nal_type <= nsi_pkg::NAL_TYPE_IDR)
			|| nal_type == nsi_pkg::NAL_TYPE_AUX_SLICE
			|| nal_type == nsi_pkg::NAL_TYPE_SLICE_EXT;
		is_pic = (nal_type == nsi_pkg::NAL_TYPE_SLICE || nal_type == nsi_pkg::NAL_TYPE_IDR)
			&& item_q.payload_present && item_q.payload_byte[nsi_pkg::FIRST_SLICE_BIT]
			&& sps_q && pps_q;
		add_point = is_pic && nal_type == nsi_pkg::NAL_TYPE_IDR
			&& seek_count_q < nsi_pkg::CNT_W'(nsi_pkg::MAX_SEEK_POINTS);
		us_n = unit_start_q;
		after_n = after_q;
		if (!is_slice && after_q) begin
			us_n = item_q.nal_offset;
			after_n = 1'b0;
		end
		if (is_pic && after_q) begin
			us_n = item_q.nal_offset;
		end
		if (is_slice) begin
			after_n = 1'b1;
		end

		nal_rsp.counted_picture = is_pic;
		nal_rsp.seek_point_added = add_point;
		nal_rsp.parameter_set = nal_type == nsi_pkg::NAL_TYPE_SPS
			|| nal_type == nsi_pkg::NAL_TYPE_PPS
			|| nal_type == nsi_pkg::NAL_TYPE_SPS_EXT
			|| nal_type == nsi_pkg::NAL_TYPE_SUBSET_SPS;
		nal_rsp.unit_start = us_n;
		nal_rsp.picture_total = (is_pic && pic_count_q != nsi_pkg::PICTURE_MAX)
			? pic_count_q + 24'd1 : pic_count_q;
		nal_rsp.mvc_present = mvc_q || nal_type == nsi_pkg::NAL_TYPE_SLICE_EXT
			|| nal_type == nsi_pkg::NAL_TYPE_SUBSET_SPS;
		nal_rsp.seek_frame = '0;
		nal_rsp.seek_offset = '0;
		nal_rsp.must_restart = 1'b0;
	end

	always_comb begin
		ans_frame = found_q ? best_frame_q : 24'd0;
		sp_off = found_q ? best_off_q : stream_start_q;
		query_rsp.counted_picture = 1'b0;
		query_rsp.seek_point_added = 1'b0;
		query_rsp.parameter_set = 1'b0;
		query_rsp.unit_start = unit_start_q;
		query_rsp.picture_total = pic_count_q;
		query_rsp.mvc_present = mvc_q;
		query_rsp.seek_frame = ans_frame;
		query_rsp.seek_offset = sp_off;
		query_rsp.must_restart = (item_q.target_frame < item_q.current_position)
			|| (ans_frame > item_q.current_position);
	end

	nsi_ram #(
		.WIDTH(nsi_pkg::SEEK_W),
		.DEPTH(nsi_pkg::MAX_SEEK_POINTS)
	) u_seek_ram (
		.clk  (clk),
		.we   (commit_nal && add_point),
		.waddr(seek_count_q[nsi_pkg::IDX_W-1:0]),
		.wdata({pic_count_q, us_n}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nsi_pkg::ST_IDLE;
			rsp_valid_q <= 1'b0;
			stream_start_q <= '0;
			unit_start_q <= '0;
			sps_q <= 1'b0;
			pps_q <= 1'b0;
			after_q <= 1'b0;
			mvc_q <= 1'b0;
			pic_count_q <= '0;
			seek_count_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			mid_q <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit_nal || answer) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				stream_start_q <= cfg_wdata;
				unit_start_q <= cfg_wdata;
			end
			if (commit_nal) begin
				unit_start_q <= us_n;
				after_q <= after_n;
				mvc_q <= nal_rsp.mvc_present;
				pic_count_q <= nal_rsp.picture_total;
				if (nal_type == nsi_pkg::NAL_TYPE_SPS) begin
					sps_q <= 1'b1;
				end
				if (nal_type == nsi_pkg::NAL_TYPE_PPS) begin
					pps_q <= 1'b1;
				end
				if (add_point) begin
					seek_count_q <= seek_count_q + 1'b1;
				end
			end
			if (take) begin
				lo_q <= '0;
				hi_q <= seek_count_q;
				mid_q <= mid0;
				found_q <= 1'b0;
			end else if (state_q == nsi_pkg::ST_SEARCH) begin
				lo_q <= lo_n;
				hi_q <= hi_n;
				mid_q <= mid_n;
				if (search_le) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_q <= req.data;
		end
		if (state_q == nsi_pkg::ST_SEARCH && search_le) begin
			best_frame_q <= rd_frame;
			best_off_q <= rd_off;
		end
		if (commit_nal) begin
			rsp_data_q <= nal_rsp;
		end else if (answer) begin
			rsp_data_q <= query_rsp;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_data_q;
endmodule

[src/nsi_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the NAL seek indexer and its bind to the top level.
module nsi_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input nsi_pkg::rsp_item_t rsp_data
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("A stalled result item changed or was dropped.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("A new item was offered a slot while one was in work.");

	a_point_is_picture: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.seek_point_added |-> rsp_data.counted_picture
			&& !rsp_data.parameter_set)
		else $error("A seek point was stored without a counted picture.");

	a_nal_no_answer: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.counted_picture || rsp_data.parameter_set)
			|-> rsp_data.seek_frame == '0 && rsp_data.seek_offset == '0
			&& !rsp_data.must_restart)
		else $error("A NAL result carries query answer fields.");
endmodule

bind nal_seek_index_core nsi_checker u_nsi_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_data (rsp.data)
);
